@@ hw/rtl/dbsp_pkg.sv @@
`timescale 1ns / 1ps

package dbsp_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_THRESHOLD_SIZE64 = 3'd0,
    REG_THRESHOLD_SIZE32 = 3'd1,
    REG_THRESHOLD_SIZE16 = 3'd2,
    REG_THRESHOLD_SIZE8  = 3'd3,
    REG_FIXED_SIZE       = 3'd4,
    REG_MAX_SIZE         = 3'd5,
    REG_WRITE_BASE_ADDR  = 3'd6,
    REG_READ_BASE_ADDR   = 3'd7
  } reg_index_t;

  localparam logic [7:0] SIZE_64 = 8'd64;
  localparam logic [7:0] SIZE_32 = 8'd32;
  localparam logic [7:0] SIZE_16 = 8'd16;
  localparam logic [7:0] SIZE_8  = 8'd8;
  localparam logic [7:0] SIZE_4  = 8'd4;

  // item data that rides alongside the divider through every cell
  typedef struct packed {
    logic        valid;
    logic [7:0]  size;
    logic [31:0] addr;
  } side_t;

  // threshold cascade over 64, 32, 16 and 8 words, falling back to 4
  function automatic logic [7:0] cascade(
    input logic [15:0] w,
    input logic [15:0] t64,
    input logic [15:0] t32,
    input logic [15:0] t16,
    input logic [15:0] t8
  );
    logic [5:0] r64;
    logic [4:0] r32;
    logic [3:0] r16;
    logic [2:0] r8;
    logic [7:0] res;
    r64 = w[5:0];
    r32 = w[4:0];
    r16 = w[3:0];
    r8  = w[2:0];
    if (w >= t64 || r64 == 6'd0 || (w > (t64 >> 1) && r64 <= 6'd16) ||
        (w > (t64 >> 2) && r64 <= 6'd8)) begin
      res = SIZE_64;
    end else if (w >= t32 || r32 == 5'd0 || (w > (t32 >> 1) && r32 <= 5'd8) ||
                 (w > (t32 >> 2) && r32 <= 5'd4)) begin
      res = SIZE_32;
    end else if (w >= t16 || r16 == 4'd0 || (w > (t16 >> 1) && r16 == 4'd4)) begin
      res = SIZE_16;
    end else if (w >= t8 || r8 == 3'd0) begin
      res = SIZE_8;
    end else begin
      res = SIZE_4;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/dbsp_div_cell.sv @@
`timescale 1ns / 1ps

// one restoring-division step: settles quotient bit IDX
module dbsp_div_cell #(
  parameter int DW  = 16,
  parameter int IDX = 15
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  dbsp_pkg::side_t side_in,
  input  logic [DW-1:0]   num_in,
  input  logic [DW-1:0]   rem_in,
  input  logic [DW-1:0]   quo_in,
  output dbsp_pkg::side_t side_out,
  output logic [DW-1:0]   num_out,
  output logic [DW-1:0]   rem_out,
  output logic [DW-1:0]   quo_out
);

  logic [DW:0]   trial;
  logic [DW:0]   divisor;
  logic          fits;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_next;
  logic [DW-1:0] quo_next;

  always_comb begin
    trial    = {rem_in, num_in[IDX]};
    divisor  = (DW + 1)'(side_in.size);
    fits     = (trial >= divisor);
    diff     = trial - divisor;
    rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    quo_next = quo_in;
    quo_next[IDX] = fits;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_out.size <= side_in.size;
      side_out.addr <= side_in.addr;
      num_out       <= num_in;
      rem_out       <= rem_next;
      quo_out       <= quo_next;
    end
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (adv) begin
      side_out.valid <= side_in.valid;
    end
  end

endmodule

@@ hw/rtl/dma_burst_size_planner_unit.sv @@
`timescale 1ns / 1ps

// dma burst size planner: takes one transfer request per cycle while in_stall is
// low and returns its packet size, packet count, leftover words and device start
// address. an item is accepted on in_valid with in_stall low; it passes the front
// stage register and then each division cell in turn, and the result appears on
// out_valid and holds while out_stall is high. the rate is set by a chain of
// division cells, one per quotient bit, that all advance together; the whole
// chain freezes only while a finished result is stalled at the output. the first
// stage picks the size (threshold cascade, fixed-size override, clamp to
// max_size) and forms the start address. configuration writes are always taken
// (cfg_ready is tied high) and must only happen while no item is in flight. a
// packet size of zero reports count 0 and leftover equal to the (masked) word count.
module dma_burst_size_planner_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] word_count,
  input  logic [15:0] word_offset,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  packet_size,
  output logic [15:0] packet_count,
  output logic [15:0] leftover_words,
  output logic [31:0] start_address,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // divider width: word count is taken in its low min(COUNT_BITS,16) bits
  localparam int DW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  // configuration registers
  logic [15:0] threshold_size64;
  logic [15:0] threshold_size32;
  logic [15:0] threshold_size16;
  logic [15:0] threshold_size8;
  logic [7:0]  fixed_size;
  logic [7:0]  max_size;
  logic [31:0] write_base_addr;
  logic [31:0] read_base_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_size64 <= 16'd2048;
      threshold_size32 <= 16'd1024;
      threshold_size16 <= 16'd512;
      threshold_size8  <= 16'd64;
      fixed_size       <= 8'd0;
      max_size         <= 8'd64;
      write_base_addr  <= 32'd0;
      read_base_addr   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (dbsp_pkg::reg_index_t'(cfg_index))
        dbsp_pkg::REG_THRESHOLD_SIZE64: threshold_size64 <= cfg_data[15:0];
        dbsp_pkg::REG_THRESHOLD_SIZE32: threshold_size32 <= cfg_data[15:0];
        dbsp_pkg::REG_THRESHOLD_SIZE16: threshold_size16 <= cfg_data[15:0];
        dbsp_pkg::REG_THRESHOLD_SIZE8:  threshold_size8  <= cfg_data[15:0];
        dbsp_pkg::REG_FIXED_SIZE:       fixed_size       <= cfg_data[7:0];
        dbsp_pkg::REG_MAX_SIZE:         max_size         <= cfg_data[7:0];
        dbsp_pkg::REG_WRITE_BASE_ADDR:  write_base_addr  <= cfg_data;
        dbsp_pkg::REG_READ_BASE_ADDR:   read_base_addr   <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole chain moves unless a finished result is held at the output
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // size selection and address
  logic [DW-1:0] words;
  logic [7:0]    casc_size;
  logic [7:0]    pick_size;
  logic [7:0]    size_next;
  logic [31:0]   addr_next;

  always_comb begin
    words     = word_count[DW-1:0];
    casc_size = dbsp_pkg::cascade(16'(words), threshold_size64, threshold_size32,
                                  threshold_size16, threshold_size8);
    pick_size = (fixed_size != 8'd0) ? fixed_size : casc_size;
    size_next = (pick_size > max_size) ? max_size : pick_size;
    addr_next = (func ? read_base_addr : write_base_addr) + {14'd0, word_offset, 2'b00};
  end

  // front stage register feeding the division chain
  dbsp_pkg::side_t side_s [DW+1];
  logic [DW-1:0]   num_s  [DW+1];
  logic [DW-1:0]   rem_s  [DW+1];
  logic [DW-1:0]   quo_s  [DW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_s[0].size <= size_next;
      side_s[0].addr <= addr_next;
      num_s[0]       <= words;
      rem_s[0]       <= '0;
      quo_s[0]       <= '0;
    end
    if (rst) begin
      side_s[0].valid <= 1'b0;
    end else if (adv) begin
      side_s[0].valid <= in_valid;
    end
  end

  // cell i settles quotient bit DW-1-i, most significant first
  for (genvar i = 0; i < DW; i++) begin : g_cell
    dbsp_div_cell #(
      .DW  (DW),
      .IDX (DW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .side_in  (side_s[i]),
      .num_in   (num_s[i]),
      .rem_in   (rem_s[i]),
      .quo_in   (quo_s[i]),
      .side_out (side_s[i+1]),
      .num_out  (num_s[i+1]),
      .rem_out  (rem_s[i+1]),
      .quo_out  (quo_s[i+1])
    );
  end

  // the last cell is the output register; a zero divisor yields all-ones
  // quotient and remainder equal to the dividend, so only the count is forced
  assign out_valid      = side_s[DW].valid;
  assign packet_size    = side_s[DW].size;
  assign start_address  = side_s[DW].addr;
  assign packet_count   = (side_s[DW].size == 8'd0) ? 16'd0 : 16'(quo_s[DW]);
  assign leftover_words = 16'(rem_s[DW]);

endmodule

@@ hw/rtl/dbsp_checker.sv @@
`timescale 1ns / 1ps

module dbsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  packet_size,
  input logic [15:0] packet_count,
  input logic [15:0] leftover_words,
  input logic [31:0] start_address
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packet_size) &&
      $stable(packet_count) && $stable(leftover_words) && $stable(start_address))
    else $error("stalled result changed");

  // input back-pressure only comes from a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // leftover is a true remainder
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_size != 8'd0 |-> leftover_words < 16'(packet_size))
    else $error("leftover not below packet size");

  // zero packet size gives no packets
  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_size == 8'd0 |-> packet_count == 16'd0)
    else $error("nonzero count with zero packet size");

endmodule

bind dma_burst_size_planner_unit dbsp_checker u_dbsp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .packet_size    (packet_size),
  .packet_count   (packet_count),
  .leftover_words (leftover_words),
  .start_address  (start_address)
);
